// File: sv/ascon_pkg.sv
// ----------------------------------------------------------------------------
// ascon_pkg: shared types, constants and round logic for the Ascon engine
// Holds the sponge state type, the AEAD128 constants, the item kind and
// register index codes, and the permutation round function.
// ----------------------------------------------------------------------------
package ascon_pkg;

   typedef logic [63:0]      word_type;
   typedef logic [4:0][63:0] sponge_type;

   // AEAD128 constants
   localparam word_type   AEAD_IV        = 64'h00001000808c0001;
   localparam int         ROUNDS_A       = 12;
   localparam int         ROUNDS_B       = 8;
   localparam int         RATE_LEN       = 16;
   localparam logic [3:0] P12_START      = 4'(ROUNDS_A - ROUNDS_A);
   localparam logic [3:0] P8_START       = 4'(ROUNDS_A - ROUNDS_B);
   localparam logic [4:0] RATE_BYTES     = 5'(RATE_LEN);
   localparam logic [4:0] LAST_ROUND_END = 5'(ROUNDS_A);

   // Item kinds
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_AD    = 2'd1;
   localparam logic [1:0] KIND_TEXT  = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_DECRYPT_MODE = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW      = 3'd1;
   localparam logic [2:0] CSR_KEY_HIGH     = 3'd2;
   localparam logic [2:0] CSR_NONCE_LOW    = 3'd3;
   localparam logic [2:0] CSR_NONCE_HIGH   = 3'd4;

   // Rotate a word right by a fixed amount
   function automatic word_type rotr(input word_type v, input int r);
      rotr = (v >> r) | (v << (64 - r));
   endfunction

   // Mask of the low min(cnt, 8) bytes of a word
   function automatic word_type byte_mask(input logic [4:0] cnt);
      word_type m;
      for (int b = 0; b < 8; b++) begin
         m[8*b +: 8] = {8{5'(b) < cnt}};
      end
      return m;
   endfunction

   // One Ascon permutation round; idx counts from 0 to 11
   function automatic sponge_type ascon_round(input sponge_type s, input logic [3:0] idx);
      word_type x0, x1, x2, x3, x4;
      word_type t0, t1, t2, t3, t4;
      sponge_type r;
      x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
      // round constant: high nibble counts down, low nibble counts up
      x2 = x2 ^ {56'd0, 4'(4'd15 - idx), idx};
      // substitution layer
      x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3;
      t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
      x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
      // linear diffusion layer
      r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
      r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
      return r;
   endfunction

endpackage

// File: sv/ascon_aead128_engine_unit.sv
// ----------------------------------------------------------------------------
// ascon_aead128_engine_unit: Ascon-AEAD128 duplex engine
// Keeps the 320-bit sponge state and runs one 16-byte block per word on a
// single shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes (index 0 decrypt mode, 1/2 key, 3/4 nonce);
//            always ready, write only while the engine is idle.
//   req_*  : one word per item; tuser is the kind (begin, associated data,
//            text). A block shorter than 16 bytes ends its phase.
//   rsp_*  : one word per text block; tlast marks the final block that
//            carries the tag, tuser is the decrypt tag-check failure.
// Timing (R = ROUNDS_PER_CYCLE):
//   The round unit applies R rounds per cycle to run p12 and p8. An item
//   occupies the engine for its accept step plus its permutation; a text
//   block then passes the emit step, which moves its word into the output
//   register. Associated data arriving after the text phase and unknown
//   kinds occupy only the accept step.
//   req_tready is high only between items.
// Reset clears the sponge, the registers and the output valid at once.
// A stalled receiver holds the output word; the engine can finish the next
// begin or associated-data item meanwhile, and a text result waits in the
// emit step until the output register is free.
// ----------------------------------------------------------------------------
module ascon_aead128_engine_unit #(
   parameter int ROUNDS_PER_CYCLE = 1
) (
   input  logic         clock,
   input  logic         reset,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: data_low[63:0], data_high[127:64], byte_count[132:128],
   //        expected_tag_low[196:133], expected_tag_high[260:197], zero fill
   input  logic [263:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]   req_tuser,
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_low[63:0], out_high[127:64], out_bytes[132:128],
   //        tag_low[196:133], tag_high[260:197], zero fill
   output logic [263:0] rsp_tdata,
   // tuser: auth_fail[0]
   output logic         rsp_tuser,
   // tlast: is_final
   output logic         rsp_tlast
);
   import ascon_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_PERM, ST_EMIT} state_type;
   typedef enum logic [1:0] {POST_NONE, POST_KEY, POST_EMIT} post_type;

   state_type  state_ff, state_in;
   post_type   post_ff, post_in;
   sponge_type x_ff, x_in;
   logic [3:0] rc_ff, rc_in;
   logic       phase_ff, phase_in;

   logic       decrypt_ff, decrypt_in;
   word_type   key_lo_ff, key_lo_in, key_hi_ff, key_hi_in;
   word_type   nonce_lo_ff, nonce_lo_in, nonce_hi_ff, nonce_hi_in;

   // pending result of the text block at work
   word_type   pend_lo_ff, pend_lo_in, pend_hi_ff, pend_hi_in;
   logic [4:0] pend_bytes_ff, pend_bytes_in;
   logic       pend_final_ff, pend_final_in;
   word_type   exp_lo_ff, exp_lo_in, exp_hi_ff, exp_hi_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [263:0] rsp_data_ff, rsp_data_in;
   logic         rsp_fail_ff, rsp_fail_in;
   logic         rsp_last_ff, rsp_last_in;

   // input unpacking
   logic [1:0] kind;
   word_type   d_lo_raw, d_hi_raw, d_lo, d_hi, m_lo, m_hi;
   logic [4:0] cnt_raw, n;
   logic       last;
   word_type   pad_lo, pad_hi;
   logic       accept;

   // round unit
   sponge_type x_round;
   logic [4:0] rc_sum;
   logic       perm_done;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fail_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Unpack the block, saturate the count and mask off unused bytes
   assign kind     = req_tuser;
   assign d_lo_raw = req_tdata[63:0];
   assign d_hi_raw = req_tdata[127:64];
   assign cnt_raw  = req_tdata[132:128];
   assign n        = (cnt_raw > RATE_BYTES) ? RATE_BYTES : cnt_raw;
   assign last     = (n < RATE_BYTES);
   assign m_lo     = byte_mask(n);
   assign m_hi     = byte_mask((n > 5'd8) ? 5'(n - 5'd8) : 5'd0);
   assign d_lo     = d_lo_raw & m_lo;
   assign d_hi     = d_hi_raw & m_hi;
   assign pad_lo   = (last && !n[3]) ? (64'd1 << {n[2:0], 3'b000}) : 64'd0;
   assign pad_hi   = (last &&  n[3]) ? (64'd1 << {n[2:0], 3'b000}) : 64'd0;

   // Shared round unit: R rounds from the current round count
   always_comb begin
      logic [4:0] idx;
      x_round = x_ff;
      for (int j = 0; j < ROUNDS_PER_CYCLE; j++) begin
         idx = {1'b0, rc_ff} + 5'(j);
         if (idx < LAST_ROUND_END) begin
            x_round = ascon_round(x_round, idx[3:0]);
         end
      end
      rc_sum    = {1'b0, rc_ff} + 5'(ROUNDS_PER_CYCLE);
      perm_done = (rc_sum >= LAST_ROUND_END);
   end

   // Sequencer and datapath next values
   always_comb begin
      sponge_type xa;
      word_type   t0, t1;
      logic       free;
      state_in      = state_ff;
      post_in       = post_ff;
      x_in          = x_ff;
      rc_in         = rc_ff;
      phase_in      = phase_ff;
      decrypt_in    = decrypt_ff;
      key_lo_in     = key_lo_ff;
      key_hi_in     = key_hi_ff;
      nonce_lo_in   = nonce_lo_ff;
      nonce_hi_in   = nonce_hi_ff;
      pend_lo_in    = pend_lo_ff;
      pend_hi_in    = pend_hi_ff;
      pend_bytes_in = pend_bytes_ff;
      pend_final_in = pend_final_ff;
      exp_lo_in     = exp_lo_ff;
      exp_hi_in     = exp_hi_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fail_in   = rsp_fail_ff;
      rsp_last_in   = rsp_last_ff;
      free          = !rsp_valid_ff || rsp_tready;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      t0            = x_ff[3] ^ key_lo_ff;
      t1            = x_ff[4] ^ key_hi_ff;
      xa            = x_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DECRYPT_MODE: decrypt_in  = csr_data[0];
            CSR_KEY_LOW:      key_lo_in   = csr_data;
            CSR_KEY_HIGH:     key_hi_in   = csr_data;
            CSR_NONCE_LOW:    nonce_lo_in = csr_data;
            CSR_NONCE_HIGH:   nonce_hi_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_BEGIN: begin
                     x_in     = {nonce_hi_ff, nonce_lo_ff, key_hi_ff, key_lo_ff,
                                 AEAD_IV};
                     rc_in    = P12_START;
                     post_in  = POST_KEY;
                     phase_in = 1'b0;
                     state_in = ST_PERM;
                  end
                  KIND_AD: begin
                     // drop associated data once text has begun
                     if (!phase_ff) begin
                        x_in[0]  = x_ff[0] ^ d_lo ^ pad_lo;
                        x_in[1]  = x_ff[1] ^ d_hi ^ pad_hi;
                        rc_in    = P8_START;
                        post_in  = POST_NONE;
                        state_in = ST_PERM;
                     end
                  end
                  KIND_TEXT: begin
                     // domain separation before the first text block
                     if (!phase_ff) begin
                        xa[4] = x_ff[4] ^ {1'b1, 63'd0};
                     end
                     phase_in   = 1'b1;
                     pend_lo_in = (x_ff[0] ^ d_lo) & m_lo;
                     pend_hi_in = (x_ff[1] ^ d_hi) & m_hi;
                     if (decrypt_ff) begin
                        xa[0] = (x_ff[0] & ~m_lo) | d_lo;
                        xa[1] = (x_ff[1] & ~m_hi) | d_hi;
                     end else begin
                        xa[0] = x_ff[0] ^ d_lo;
                        xa[1] = x_ff[1] ^ d_hi;
                     end
                     pend_bytes_in = n;
                     pend_final_in = last;
                     exp_lo_in     = req_tdata[196:133];
                     exp_hi_in     = req_tdata[260:197];
                     if (last) begin
                        // pad, then key into the capacity ahead of p12
                        xa[0] = xa[0] ^ pad_lo;
                        xa[1] = xa[1] ^ pad_hi;
                        xa[2] = xa[2] ^ key_lo_ff;
                        xa[3] = xa[3] ^ key_hi_ff;
                        rc_in = P12_START;
                     end else begin
                        rc_in = P8_START;
                     end
                     x_in     = xa;
                     post_in  = POST_EMIT;
                     state_in = ST_PERM;
                  end
                  default: ;
               endcase
            end
         end
         ST_PERM: begin
            x_in  = x_round;
            rc_in = rc_sum[3:0];
            if (perm_done) begin
               rc_in = 4'd0;
               unique case (post_ff)
                  POST_KEY: begin
                     x_in[3]  = x_round[3] ^ key_lo_ff;
                     x_in[4]  = x_round[4] ^ key_hi_ff;
                     state_in = ST_IDLE;
                  end
                  POST_EMIT: state_in = ST_EMIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            // load the output register once it is free
            if (free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = pend_final_ff;
               if (pend_final_ff) begin
                  rsp_data_in = {3'b000, t1, t0, pend_bytes_ff, pend_hi_ff, pend_lo_ff};
                  rsp_fail_in = decrypt_ff && (((t0 ^ exp_lo_ff) | (t1 ^ exp_hi_ff)) != 64'd0);
               end else begin
                  rsp_data_in = {3'b000, 128'd0, pend_bytes_ff, pend_hi_ff, pend_lo_ff};
                  rsp_fail_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         post_ff      <= POST_NONE;
         x_ff         <= '0;
         rc_ff        <= 4'd0;
         phase_ff     <= 1'b0;
         decrypt_ff   <= 1'b0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         x_ff         <= x_in;
         rc_ff        <= rc_in;
         phase_ff     <= phase_in;
         decrypt_ff   <= decrypt_in;
         key_lo_ff    <= key_lo_in;
         key_hi_ff    <= key_hi_in;
         nonce_lo_ff  <= nonce_lo_in;
         nonce_hi_ff  <= nonce_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_lo_ff    <= pend_lo_in;
      pend_hi_ff    <= pend_hi_in;
      pend_bytes_ff <= pend_bytes_in;
      pend_final_ff <= pend_final_in;
      exp_lo_ff     <= exp_lo_in;
      exp_hi_ff     <= exp_hi_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fail_ff   <= rsp_fail_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Round count rests at zero between items
   a_rc_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_PERM |-> rc_ff == 4'd0)
      else $error("round count not zero outside permutation");

   // A new result word only comes out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result word raised outside emit step");

   // Tag check failure only on a final decrypt word
   a_fail_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fail_ff |-> rsp_last_ff && decrypt_ff)
      else $error("auth failure flagged on a non-final or encrypt word");

   // Non-final words carry a zero tag
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_data_ff[260:133] == 128'd0)
      else $error("tag present on a non-final word");

endmodule

// File: test/ascon_aead128_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// ascon_aead128_engine_unit_tb: self-checking bench for the Ascon-AEAD128 engine
// A short directed pass covers the extremes, every item kind, padding, count
// saturation and the tag check; then random messages follow, some broken and
// mixed with noise. A behavioral duplex model predicts all but hand-typed result words.
// ----------------------------------------------------------------------------
module ascon_aead128_engine_unit_tb;
   import ascon_pkg::*;

   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam logic [2:0] CSR_UNMAPPED  = 3'd7;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         STALL_LIMIT   = 3000;
   localparam int         RANDOM_WORDS  = 700;

   typedef enum logic [1:0] {TAG_RANDOM, TAG_MATCH, TAG_FLIP} tag_pick_type;
   typedef enum logic [1:0] {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_HOLD} pace_type;

   typedef struct packed {
      logic [1:0] kind;
      word_type   data_lo;
      word_type   data_hi;
      logic [4:0] count;
      word_type   tag_lo;
      word_type   tag_hi;
   } block_type;

   typedef struct packed {
      word_type   out_lo;
      word_type   out_hi;
      logic [4:0] out_bytes;
      logic       is_final;
      word_type   tag_lo;
      word_type   tag_hi;
      logic       auth_fail;
   } text_out_type;

   typedef struct packed {
      sponge_type x;
      logic       text_on;
      logic       decrypt;
      word_type   key_lo;
      word_type   key_hi;
      word_type   nonce_lo;
      word_type   nonce_hi;
   } duplex_type;

   typedef struct packed {
      logic         is_reg;
      logic [2:0]   reg_index;
      word_type     reg_value;
      block_type    blk;
      tag_pick_type tag_pick;
      logic         typed;
      logic         typed_has;
      text_out_type typed_out;
   } plan_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = '0;
   logic [63:0]  csr_data   = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [263:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   duplex_type   engine = '0;
   text_out_type pending_out [$];
   plan_row_type directed_rows [$];
   int           fail_count  = 0;
   int           live_words  = 0;
   int           burst_left  = 0;
   int           quiet_cycles = 0;
   bit           owes_settle = 1'b0;
   pace_type     pace_mode   = PACE_OPEN;
   int           pace_left   = 0;
   int           pace_tick   = 0;
   int           hold_left   = 0;

   ascon_aead128_engine_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Duplex model
   // ------------------------------------------------------------------------
   function automatic word_type rot_right(input word_type v, input int r);
      return (v >> r) | (v << (64 - r));
   endfunction

   function automatic sponge_type mix_round(input sponge_type s, input int idx);
      word_type a0, a1, a2, a3, a4;
      word_type c0, c1, c2, c3, c4;
      sponge_type r;
      a0 = s[0]; a1 = s[1]; a2 = s[2]; a3 = s[3]; a4 = s[4];
      a2 = a2 ^ {56'd0, 4'(15 - idx), 4'(idx)};
      // s-box, bit sliced
      a0 = a0 ^ a4; a4 = a4 ^ a3; a2 = a2 ^ a1;
      c0 = ~a0 & a1; c1 = ~a1 & a2; c2 = ~a2 & a3; c3 = ~a3 & a4; c4 = ~a4 & a0;
      a0 = a0 ^ c1; a1 = a1 ^ c2; a2 = a2 ^ c3; a3 = a3 ^ c4; a4 = a4 ^ c0;
      a1 = a1 ^ a0; a0 = a0 ^ a4; a3 = a3 ^ a2; a2 = ~a2;
      // diffusion
      r[0] = a0 ^ rot_right(a0, 19) ^ rot_right(a0, 28);
      r[1] = a1 ^ rot_right(a1, 61) ^ rot_right(a1, 39);
      r[2] = a2 ^ rot_right(a2, 1)  ^ rot_right(a2, 6);
      r[3] = a3 ^ rot_right(a3, 10) ^ rot_right(a3, 17);
      r[4] = a4 ^ rot_right(a4, 7)  ^ rot_right(a4, 41);
      return r;
   endfunction

   // Run the last nrounds of the twelve
   function automatic sponge_type run_rounds(input sponge_type s, input int nrounds);
      for (int i = ROUNDS_A - nrounds; i < ROUNDS_A; i++) begin
         s = mix_round(s, i);
      end
      return s;
   endfunction

   function automatic word_type lane_mask(input int cnt);
      if (cnt >= 8) return '1;
      return (64'd1 << (8 * cnt)) - 64'd1;
   endfunction

   function automatic sponge_type add_padding(input sponge_type s, input int n);
      if (n < 8) s[0] = s[0] ^ (64'd1 << (8 * n));
      else s[1] = s[1] ^ (64'd1 << (8 * (n - 8)));
      return s;
   endfunction

   // Advance the duplex by one item; return 1 when a text word comes out
   function automatic bit duplex_step(input duplex_type cur, input block_type b,
                                      output duplex_type nxt, output text_out_type o);
      int n;
      bit last;
      logic [1:0][63:0] m, d, lane;
      nxt = cur;
      o = '0;
      n = (b.count > 5'd16) ? 16 : int'(b.count);
      last = (n < RATE_LEN);
      m[0] = lane_mask(n);
      m[1] = lane_mask(n > 8 ? n - 8 : 0);
      d[0] = b.data_lo & m[0];
      d[1] = b.data_hi & m[1];
      if (b.kind == KIND_BEGIN) begin
         nxt.x[0] = AEAD_IV;
         nxt.x[1] = cur.key_lo;
         nxt.x[2] = cur.key_hi;
         nxt.x[3] = cur.nonce_lo;
         nxt.x[4] = cur.nonce_hi;
         nxt.x = run_rounds(nxt.x, ROUNDS_A);
         nxt.x[3] = nxt.x[3] ^ cur.key_lo;
         nxt.x[4] = nxt.x[4] ^ cur.key_hi;
         nxt.text_on = 1'b0;
         return 1'b0;
      end
      if (b.kind == KIND_AD) begin
         // associated data is dropped once text has started
         if (!cur.text_on) begin
            nxt.x[0] = nxt.x[0] ^ d[0];
            nxt.x[1] = nxt.x[1] ^ d[1];
            if (last) nxt.x = add_padding(nxt.x, n);
            nxt.x = run_rounds(nxt.x, ROUNDS_B);
         end
         return 1'b0;
      end
      if (b.kind != KIND_TEXT) return 1'b0;

      // domain separation before the first text word
      if (!nxt.text_on) begin
         nxt.x[4][63] = ~nxt.x[4][63];
         nxt.text_on = 1'b1;
      end
      for (int i = 0; i < 2; i++) begin
         if (cur.decrypt) begin
            lane[i] = (nxt.x[i] ^ d[i]) & m[i];
            nxt.x[i] = (nxt.x[i] & ~m[i]) | d[i];
         end else begin
            nxt.x[i] = nxt.x[i] ^ d[i];
            lane[i] = nxt.x[i] & m[i];
         end
      end
      o.out_lo = lane[0];
      o.out_hi = lane[1];
      o.out_bytes = 5'(n);
      if (!last) begin
         nxt.x = run_rounds(nxt.x, ROUNDS_B);
         return 1'b1;
      end
      // finalize and produce the tag
      nxt.x = add_padding(nxt.x, n);
      nxt.x[2] = nxt.x[2] ^ cur.key_lo;
      nxt.x[3] = nxt.x[3] ^ cur.key_hi;
      nxt.x = run_rounds(nxt.x, ROUNDS_A);
      o.is_final = 1'b1;
      o.tag_lo = nxt.x[3] ^ cur.key_lo;
      o.tag_hi = nxt.x[4] ^ cur.key_hi;
      o.auth_fail = cur.decrypt && ({o.tag_hi, o.tag_lo} != {b.tag_hi, b.tag_lo});
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic plan_row_type make_row(input logic [1:0] kind, input logic [4:0] cnt);
      plan_row_type row;
      row = '0;
      row.blk.kind = kind;
      row.blk.data_lo = {$urandom, $urandom};
      row.blk.data_hi = {$urandom, $urandom};
      row.blk.count = cnt;
      row.blk.tag_lo = {$urandom, $urandom};
      row.blk.tag_hi = {$urandom, $urandom};
      row.tag_pick = TAG_RANDOM;
      return row;
   endfunction

   function automatic logic [4:0] full_count();
      if ($urandom_range(0, 3) == 0) return 5'($urandom_range(17, 31));
      return RATE_BYTES;
   endfunction

   function automatic void plan_item(input logic [1:0] kind, input word_type lo,
                                     input word_type hi, input logic [4:0] cnt,
                                     input tag_pick_type pick);
      plan_row_type row;
      row = make_row(kind, cnt);
      row.blk.data_lo = lo;
      row.blk.data_hi = hi;
      row.tag_pick = pick;
      directed_rows.push_back(row);
   endfunction

   // Item whose lack of output is plain to see
   function automatic void plan_none(input logic [1:0] kind, input word_type lo,
                                     input word_type hi, input logic [4:0] cnt);
      plan_row_type row;
      row = make_row(kind, cnt);
      row.blk.data_lo = lo;
      row.blk.data_hi = hi;
      row.typed = 1'b1;
      row.typed_has = 1'b0;
      directed_rows.push_back(row);
   endfunction

   function automatic void plan_reg(input logic [2:0] idx, input word_type val);
      plan_row_type row;
      row = '0;
      row.is_reg = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      directed_rows.push_back(row);
   endfunction

   // Drop valid, wait out every owed word and the tail of a silent item
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      owes_settle = 1'b0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input word_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DECRYPT_MODE: engine.decrypt  = val[0];
         CSR_KEY_LOW:      engine.key_lo   = val;
         CSR_KEY_HIGH:     engine.key_hi   = val;
         CSR_NONCE_LOW:    engine.nonce_lo = val;
         CSR_NONCE_HIGH:   engine.nonce_hi = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Send one item word in bursts; predict its output once it is taken
   task automatic send_block(input plan_row_type row);
      duplex_type after;
      text_out_type out;
      bit has;
      block_type b;
      logic [127:0] tag_bits;
      int flip_at;
      b = row.blk;
      if (row.tag_pick != TAG_RANDOM) begin
         void'(duplex_step(engine, b, after, out));
         tag_bits = {out.tag_hi, out.tag_lo};
         if (row.tag_pick == TAG_FLIP) begin
            flip_at = $urandom_range(0, 127);
            tag_bits[flip_at] = ~tag_bits[flip_at];
         end
         {b.tag_hi, b.tag_lo} = tag_bits;
      end
      if (b.kind == KIND_BEGIN || b.kind == KIND_TEXT ||
          (b.kind == KIND_AD && !engine.text_on))
         live_words++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= b.kind;
      req_tdata  <= {3'b000, b.tag_hi, b.tag_lo, b.count, b.data_hi, b.data_lo};
      do @(posedge clock); while (!req_tready);
      has = duplex_step(engine, b, after, out);
      engine = after;
      if (row.typed) begin
         has = row.typed_has;
         out = row.typed_out;
      end
      if (has) pending_out.push_back(out);
      owes_settle = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input word_type want,
                                       input word_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      text_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_lo    = rsp_tdata[63:0];
         got.out_hi    = rsp_tdata[127:64];
         got.out_bytes = rsp_tdata[132:128];
         got.tag_lo    = rsp_tdata[196:133];
         got.tag_hi    = rsp_tdata[260:197];
         got.is_final  = rsp_tlast;
         got.auth_fail = rsp_tuser;
         if (pending_out.size() == 0) begin
            $display("%0t: result word mismatch: expected none, actual out %h_%h",
                     $time, got.out_hi, got.out_lo);
            $display("   bytes %0d final %b tag %h_%h auth %b",
                     got.out_bytes, got.is_final, got.tag_hi, got.tag_lo,
                     got.auth_fail);
            fail_count++;
         end else begin
            want = pending_out.pop_front();
            check_field("out_low",   want.out_lo, got.out_lo);
            check_field("out_high",  want.out_hi, got.out_hi);
            check_field("out_bytes", word_type'(want.out_bytes),
                        word_type'(got.out_bytes));
            check_field("is_final",  word_type'(want.is_final),
                        word_type'(got.is_final));
            check_field("tag_low",   want.tag_lo, got.tag_lo);
            check_field("tag_high",  want.tag_hi, got.tag_hi);
            check_field("auth_fail", word_type'(want.auth_fail),
                        word_type'(got.auth_fail));
         end
      end
   end

   // Receiver pacing: switch between open, coin-flip, sparse and hold patterns
   always @(posedge clock) begin
      if (pace_left == 0) begin
         pace_mode = pace_type'($urandom_range(0, 3));
         pace_left = $urandom_range(20, 120);
      end
      pace_left--;
      pace_tick++;
      case (pace_mode)
         PACE_OPEN:   rsp_tready <= 1'b1;
         PACE_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         PACE_SPARSE: rsp_tready <= (pace_tick % 4 == 0);
         default: begin
            if (hold_left == 0) begin
               rsp_tready <= 1'b1;
               hold_left = $urandom_range(1, 12);
            end else begin
               rsp_tready <= 1'b0;
               hold_left--;
            end
         end
      endcase
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("** ascon_aead128_engine_unit: FAILED **");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type row;
      plan_row_type msg [$];
      int random_goal, next_break, ad_blocks, cut;
      word_type setting;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // after reset the sponge is zero: a full text word comes back unchanged
      row = make_row(KIND_TEXT, 5'd31);
      row.blk.data_lo = '1;
      row.blk.data_hi = '1;
      row.typed = 1'b1;
      row.typed_has = 1'b1;
      row.typed_out = '0;
      row.typed_out.out_lo = '1;
      row.typed_out.out_hi = '1;
      row.typed_out.out_bytes = RATE_BYTES;
      directed_rows.push_back(row);
      plan_none(KIND_AD, '1, '1, 5'd16);
      plan_none(KIND_RESERVED, '1, '1, 5'd31);
      plan_item(KIND_TEXT, '1, '1, 5'd0, TAG_RANDOM);
      // all-ones key and nonce, encrypt
      plan_reg(CSR_KEY_LOW, '1);
      plan_reg(CSR_KEY_HIGH, '1);
      plan_reg(CSR_NONCE_LOW, '1);
      plan_reg(CSR_NONCE_HIGH, '1);
      plan_reg(CSR_DECRYPT_MODE, '0);
      plan_none(KIND_BEGIN, '1, '1, 5'd16);
      plan_item(KIND_AD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16, TAG_RANDOM);
      plan_item(KIND_AD, '1, '1, 5'd0, TAG_RANDOM);
      plan_item(KIND_AD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd7, TAG_RANDOM);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16, TAG_RANDOM);
      plan_item(KIND_TEXT, '1, '1, 5'd8, TAG_RANDOM);
      // all-zero key and nonce, decrypt with good and bad tags
      plan_reg(CSR_DECRYPT_MODE, '1);
      plan_reg(CSR_KEY_LOW, '0);
      plan_reg(CSR_KEY_HIGH, '0);
      plan_reg(CSR_NONCE_LOW, '0);
      plan_reg(CSR_NONCE_HIGH, '0);
      plan_none(KIND_BEGIN, '0, '0, 5'd0);
      plan_item(KIND_TEXT, '1, '1, 5'd15, TAG_MATCH);
      plan_none(KIND_BEGIN, '1, '1, 5'd31);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd9, TAG_FLIP);
      plan_none(KIND_BEGIN, '0, '0, 5'd16);
      plan_item(KIND_AD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd1, TAG_RANDOM);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd17, TAG_RANDOM);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd0, TAG_MATCH);
      // text after the final word runs on the state as it stands
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16, TAG_RANDOM);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd1, TAG_RANDOM);
      plan_reg(CSR_UNMAPPED, '1);
      plan_reg(CSR_DECRYPT_MODE, '0);
      plan_reg(CSR_KEY_LOW, {$urandom, $urandom});
      plan_none(KIND_BEGIN, '0, '0, 5'd0);
      plan_item(KIND_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 5'd12, TAG_RANDOM);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_reg) begin
            if (owes_settle) settle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_block(directed_rows[i]);
         end
      end

      // random messages, with register changes between messages after every 60 to 150 live words
      random_goal = live_words + RANDOM_WORDS;
      next_break = live_words + $urandom_range(60, 150);
      while (live_words < random_goal) begin
         if (live_words >= next_break) begin
            settle();
            if ($urandom_range(0, 3) == 0) write_reg(CSR_UNMAPPED, {$urandom, $urandom});
            write_reg(CSR_DECRYPT_MODE, {$urandom, $urandom});
            for (int k = CSR_KEY_LOW; k <= CSR_NONCE_HIGH; k++) begin
               if ($urandom_range(0, 1) == 1) begin
                  case ($urandom_range(0, 5))
                     0: setting = '0;
                     1: setting = '1;
                     default: setting = {$urandom, $urandom};
                  endcase
                  write_reg(3'(k), setting);
               end
            end
            next_break = live_words + $urandom_range(60, 150);
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: any kind, any count
            send_block(make_row(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31))));
         end else begin
            msg.delete();
            msg.push_back(make_row(KIND_BEGIN, 5'($urandom_range(0, 31))));
            ad_blocks = $urandom_range(0, 3);
            if (ad_blocks != 0) begin
               repeat (ad_blocks - 1) msg.push_back(make_row(KIND_AD, full_count()));
               msg.push_back(make_row(KIND_AD, 5'($urandom_range(0, 15))));
            end
            repeat ($urandom_range(0, 3)) msg.push_back(make_row(KIND_TEXT, full_count()));
            row = make_row(KIND_TEXT, 5'($urandom_range(0, 15)));
            row.tag_pick = tag_pick_type'($urandom_range(0, 2));
            msg.push_back(row);
            // now and then break the message off early
            if ($urandom_range(0, 7) == 0) begin
               cut = $urandom_range(1, msg.size() - 1);
               while (msg.size() > cut) void'(msg.pop_back());
            end
            foreach (msg[i]) send_block(msg[i]);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("** ascon_aead128_engine_unit: PASSED **");
      end else begin
         $display("** ascon_aead128_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule
